// ===== sv/cte_pkg.sv =====
// ----------------------------------------------------------------------------
// cte_pkg: shared types and helpers for the calendar time field editor
// command codes, field limits, editor state record and field step helpers
// ----------------------------------------------------------------------------
`default_nettype none

package cte_pkg;

  localparam int unsigned HALF_W = 16;
  localparam logic [HALF_W-1:0] BLINK_HALF_RESET = 16'd500;

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0,
    CMD_MODE = 3'd1,
    CMD_NEXT = 3'd2,
    CMD_UP   = 3'd3,
    CMD_DOWN = 3'd4,
    CMD_LOAD = 3'd5
  } cte_cmd_t;

  // cursor positions
  localparam logic [2:0] FIELD_YEAR   = 3'd0;
  localparam logic [2:0] FIELD_MONTH  = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_HOUR   = 3'd3;
  localparam logic [2:0] FIELD_MINUTE = 3'd4;
  localparam logic [2:0] FIELD_SECOND = 3'd5;

  localparam logic [6:0] YEAR_MIN   = 7'd0;
  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [6:0] MONTH_MIN  = 7'd1;
  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] HOUR_MIN   = 7'd0;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINUTE_MIN = 7'd0;
  localparam logic [6:0] MINUTE_MAX = 7'd59;
  localparam logic [6:0] SECOND_MIN = 7'd0;
  localparam logic [6:0] SECOND_MAX = 7'd59;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cte_fields_t;

  typedef struct packed {
    cte_fields_t       fields;
    logic [2:0]        cursor;
    logic              edit;
    logic              blink;
    logic [HALF_W-1:0] tick;
  } cte_state_t;

  // every year divisible by 4 is leap; bad month codes count as 31 days
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
    logic [4:0] len;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // up: past max wraps to min; down: at or below min wraps to max
  function automatic logic [6:0] step_wrap(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi, input logic up);
    logic [7:0] inc;
    logic [6:0] res;
    inc = {1'b0, v} + 8'd1;
    if (up) begin
      res = (inc > {1'b0, hi}) ? lo : inc[6:0];
    end else begin
      res = (v <= lo) ? hi : v - 7'd1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cte_step.sv =====
// ----------------------------------------------------------------------------
// cte_step: next-state logic of the editor
// applies one command to the editor state, single combinational pass
// ----------------------------------------------------------------------------
`default_nettype none

module cte_step
  import cte_pkg::*;
(
  input  cte_state_t        cur,
  input  logic [2:0]        cmd,
  input  cte_fields_t       load,
  input  logic [HALF_W-1:0] half_period,
  output cte_state_t        nxt,
  output logic              commit
);

  logic [HALF_W:0] tick_inc;
  logic [4:0]      lim_cur;
  logic [5:0]      day_inc;
  logic            up;

  assign tick_inc = {1'b0, cur.tick} + {{HALF_W{1'b0}}, 1'b1};
  assign lim_cur  = month_len(cur.fields.month, cur.fields.year);
  assign day_inc  = {1'b0, cur.fields.day} + 6'd1;
  assign up       = (cte_cmd_t'(cmd) == CMD_UP);

  always_comb begin
    nxt    = cur;
    commit = 1'b0;
    case (cte_cmd_t'(cmd))
      CMD_TICK: begin
        if (tick_inc >= {1'b0, half_period}) begin
          nxt.tick  = '0;
          nxt.blink = ~cur.blink;
        end else begin
          nxt.tick = tick_inc[HALF_W-1:0];
        end
      end
      CMD_MODE: begin
        if (cur.edit) begin
          nxt.edit = 1'b0;
          commit   = 1'b1;
        end else begin
          nxt.edit   = 1'b1;
          nxt.cursor = FIELD_YEAR;
        end
      end
      CMD_NEXT: begin
        if (cur.edit) begin
          nxt.cursor = (cur.cursor == FIELD_SECOND) ? FIELD_YEAR : cur.cursor + 3'd1;
        end
      end
      CMD_UP, CMD_DOWN: begin
        if (cur.edit) begin
          case (cur.cursor)
            FIELD_YEAR: begin
              nxt.fields.year = step_wrap(cur.fields.year, YEAR_MIN, YEAR_MAX, up);
            end
            FIELD_MONTH: begin
              nxt.fields.month = 4'(step_wrap({3'b000, cur.fields.month},
                                              MONTH_MIN, MONTH_MAX, up));
            end
            FIELD_DAY: begin
              if (up) begin
                nxt.fields.day = day_inc[4:0];
              end else begin
                nxt.fields.day = (cur.fields.day <= 5'd1) ? lim_cur : cur.fields.day - 5'd1;
              end
            end
            FIELD_HOUR: begin
              nxt.fields.hour = 5'(step_wrap({2'b00, cur.fields.hour}, HOUR_MIN, HOUR_MAX, up));
            end
            FIELD_MINUTE: begin
              nxt.fields.minute = 6'(step_wrap({1'b0, cur.fields.minute},
                                               MINUTE_MIN, MINUTE_MAX, up));
            end
            FIELD_SECOND: begin
              nxt.fields.second = 6'(step_wrap({1'b0, cur.fields.second},
                                               SECOND_MIN, SECOND_MAX, up));
            end
            default: ;
          endcase
          // day repair against the month length after the step
          if (nxt.fields.day == 5'd0 ||
              nxt.fields.day > month_len(nxt.fields.month, nxt.fields.year)) begin
            nxt.fields.day = 5'd1;
          end
        end
      end
      CMD_LOAD: begin
        if (!cur.edit) begin
          nxt.fields = load;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/calendar_time_field_editor.sv =====
// ----------------------------------------------------------------------------
// calendar_time_field_editor: date and time setting editor
// six date/time fields with cursor, edit mode, blink timer and commit pulse
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  cfg     | in        | cfg_valid/cfg_ready | cfg_data: blink half period
//  in      | in        | in_valid/in_ready   | command and load_* clock reading
//  out     | out       | out_valid/out_ready | fields, cursor, flags, commit
//
// one item per cycle sustained while out_ready is high; each item goes through
// the input register, then one pass of next-state logic into the result register
// rst_n is synchronous: editor state cleared, half period back to 500
// a stalled result holds the result register; the input register still takes
// one more item, after which in_ready drops until the result side drains
// cfg_ready is always high
`default_nettype none

module calendar_time_field_editor
  import cte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [HALF_W-1:0] cfg_data,
  // commands
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_command,
  input  logic [6:0]        in_load_year,
  input  logic [3:0]        in_load_month,
  input  logic [4:0]        in_load_day,
  input  logic [4:0]        in_load_hour,
  input  logic [5:0]        in_load_minute,
  input  logic [5:0]        in_load_second,
  // results
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        out_year,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [5:0]        out_second,
  output logic [2:0]        out_selected_field,
  output logic              out_editing,
  output logic              out_blink_on,
  output logic              out_commit
);

  // blink half period register
  logic [HALF_W-1:0] half_r;

  // input register
  logic        in_valid_r;
  logic [2:0]  in_cmd_r;
  cte_fields_t in_load_r;

  // editor state
  cte_state_t  state_r;
  cte_state_t  state_nxt;
  logic        commit_nxt;

  // result register
  logic        out_valid_r;
  cte_fields_t out_fields_r;
  logic [2:0]  out_cursor_r;
  logic        out_edit_r;
  logic        out_blink_r;
  logic        out_commit_r;

  logic        advance;

  // item moves from input register to result register when the latter is free
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= BLINK_HALF_RESET;
    end else if (cfg_valid) begin
      half_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // payload capture on every input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r         <= in_command;
      in_load_r.year   <= in_load_year;
      in_load_r.month  <= in_load_month;
      in_load_r.day    <= in_load_day;
      in_load_r.hour   <= in_load_hour;
      in_load_r.minute <= in_load_minute;
      in_load_r.second <= in_load_second;
    end
  end

  cte_step u_step (
    .cur         (state_r),
    .cmd         (in_cmd_r),
    .load        (in_load_r),
    .half_period (half_r),
    .nxt         (state_nxt),
    .commit      (commit_nxt)
  );

  // state only moves when its item is handed to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_fields_r <= state_nxt.fields;
      out_cursor_r <= state_nxt.cursor;
      out_edit_r   <= state_nxt.edit;
      // blink only shows while editing
      out_blink_r  <= state_nxt.edit && state_nxt.blink;
      out_commit_r <= commit_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_year           = out_fields_r.year;
  assign out_month          = out_fields_r.month;
  assign out_day            = out_fields_r.day;
  assign out_hour           = out_fields_r.hour;
  assign out_minute         = out_fields_r.minute;
  assign out_second         = out_fields_r.second;
  assign out_selected_field = out_cursor_r;
  assign out_editing        = out_edit_r;
  assign out_blink_on       = out_blink_r;
  assign out_commit         = out_commit_r;

  // cursor stays on one of the six fields
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.cursor <= FIELD_SECOND)
    else $error("cursor out of range");

  // commit only on the result that leaves edit mode
  a_commit_leaves_edit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_commit_r |-> !out_edit_r)
    else $error("commit while still editing");

  // blanking only while editing
  a_blink_needs_edit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_blink_r |-> out_edit_r)
    else $error("blink shown outside edit mode");

  // input side stalls only with a full input register behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without cause");

endmodule

`default_nettype wire

// ===== sim/cte_editor_checker.sv =====
// ----------------------------------------------------------------------------
// cte_editor_checker: result checker for the calendar time field editor
// tracks the editor state from observed transfers and compares every result
// ----------------------------------------------------------------------------
module cte_editor_checker
  import cte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [HALF_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_command,
  input  logic [6:0]        in_load_year,
  input  logic [3:0]        in_load_month,
  input  logic [4:0]        in_load_day,
  input  logic [4:0]        in_load_hour,
  input  logic [5:0]        in_load_minute,
  input  logic [5:0]        in_load_second,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [6:0]        out_year,
  input  logic [3:0]        out_month,
  input  logic [4:0]        out_day,
  input  logic [4:0]        out_hour,
  input  logic [5:0]        out_minute,
  input  logic [5:0]        out_second,
  input  logic [2:0]        out_selected_field,
  input  logic              out_editing,
  input  logic              out_blink_on,
  input  logic              out_commit,
  output int                n_fail,
  output int                n_pending,
  output int                n_checked,
  output int                n_commits
);

  typedef struct packed {
    cte_fields_t fields;
    logic [2:0]  cursor;
    logic        editing;
    logic        blink_on;
    logic        commit;
  } editor_view_t;

  editor_view_t pending_views[$];

  int   field_val[6];
  int   cursor_pos;
  logic in_edit;
  logic blink_state;
  int   tick_run;
  int   half_period;
  int   fail_cnt;
  int   checked_cnt;
  int   commit_cnt;

  // every year divisible by 4 counts as leap, bad month codes as 31 days
  function automatic int days_in(input int m, input int y);
    if (m == 2) return (y % 4 == 0) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  task automatic flag_field(input string what, input int want, input int got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // apply one command to the tracked state and queue the view it produces
  task automatic advance_editor(input logic [2:0] cmd, input cte_fields_t rd);
    int           f;
    int           v;
    int           lo;
    int           hi;
    int           mask;
    int           lim;
    logic         commit_now;
    editor_view_t view;
    commit_now = 1'b0;
    case (cmd)
      CMD_TICK: begin
        // a half period of zero behaves like one
        if (tick_run + 1 >= half_period) begin
          tick_run    = 0;
          blink_state = !blink_state;
        end else begin
          tick_run++;
        end
      end
      CMD_MODE: begin
        if (in_edit) begin
          in_edit    = 1'b0;
          commit_now = 1'b1;
        end else begin
          in_edit    = 1'b1;
          cursor_pos = FIELD_YEAR;
        end
      end
      CMD_NEXT: begin
        if (in_edit) cursor_pos = (cursor_pos + 1) % 6;
      end
      CMD_UP, CMD_DOWN: begin
        if (in_edit) begin
          f = cursor_pos;
          v = field_val[f];
          case (f)
            FIELD_YEAR: begin
              lo = YEAR_MIN; hi = YEAR_MAX; mask = 'h7f;
            end
            FIELD_MONTH: begin
              lo = MONTH_MIN; hi = MONTH_MAX; mask = 'h0f;
            end
            FIELD_DAY: begin
              lo = 1; hi = 31; mask = 'h1f;
            end
            FIELD_HOUR: begin
              lo = HOUR_MIN; hi = HOUR_MAX; mask = 'h1f;
            end
            FIELD_MINUTE: begin
              lo = MINUTE_MIN; hi = MINUTE_MAX; mask = 'h3f;
            end
            default: begin
              lo = SECOND_MIN; hi = SECOND_MAX; mask = 'h3f;
            end
          endcase
          if (f == FIELD_DAY) begin
            // day steps against the month length; overflow is repaired below
            lim = days_in(field_val[FIELD_MONTH], field_val[FIELD_YEAR]);
            if (cmd == CMD_UP) v = v + 1;
            else v = (v <= 1) ? lim : v - 1;
          end else if (cmd == CMD_UP) begin
            v = v + 1;
            if (v > hi) v = lo;
          end else begin
            v = (v <= lo) ? hi : v - 1;
          end
          field_val[f] = v & mask;
          lim = days_in(field_val[FIELD_MONTH], field_val[FIELD_YEAR]);
          if (field_val[FIELD_DAY] == 0 || field_val[FIELD_DAY] > lim)
            field_val[FIELD_DAY] = 1;
        end
      end
      CMD_LOAD: begin
        if (!in_edit) begin
          field_val[FIELD_YEAR]   = rd.year;
          field_val[FIELD_MONTH]  = rd.month;
          field_val[FIELD_DAY]    = rd.day;
          field_val[FIELD_HOUR]   = rd.hour;
          field_val[FIELD_MINUTE] = rd.minute;
          field_val[FIELD_SECOND] = rd.second;
        end
      end
      default: ;
    endcase
    view.fields.year   = 7'(field_val[FIELD_YEAR]);
    view.fields.month  = 4'(field_val[FIELD_MONTH]);
    view.fields.day    = 5'(field_val[FIELD_DAY]);
    view.fields.hour   = 5'(field_val[FIELD_HOUR]);
    view.fields.minute = 6'(field_val[FIELD_MINUTE]);
    view.fields.second = 6'(field_val[FIELD_SECOND]);
    view.cursor        = 3'(cursor_pos);
    view.editing       = in_edit;
    view.blink_on      = in_edit && blink_state;
    view.commit        = commit_now;
    pending_views.push_back(view);
  endtask

  always @(posedge clk) begin : watch
    editor_view_t want;
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) field_val[i] = 0;
      cursor_pos  = 0;
      in_edit     = 1'b0;
      blink_state = 1'b0;
      tick_run    = 0;
      half_period = BLINK_HALF_RESET;
      fail_cnt    = 0;
      checked_cnt = 0;
      commit_cnt  = 0;
      pending_views.delete();
    end else begin
      if (cfg_valid && cfg_ready) half_period = cfg_data;
      if (out_valid && out_ready) begin
        if (pending_views.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("[%0t] result transfer with no command behind it", $time);
        end else begin
          want = pending_views.pop_front();
          checked_cnt++;
          if (out_year !== want.fields.year)
            flag_field("year", want.fields.year, out_year);
          if (out_month !== want.fields.month)
            flag_field("month", want.fields.month, out_month);
          if (out_day !== want.fields.day)
            flag_field("day", want.fields.day, out_day);
          if (out_hour !== want.fields.hour)
            flag_field("hour", want.fields.hour, out_hour);
          if (out_minute !== want.fields.minute)
            flag_field("minute", want.fields.minute, out_minute);
          if (out_second !== want.fields.second)
            flag_field("second", want.fields.second, out_second);
          if (out_selected_field !== want.cursor)
            flag_field("selected_field", want.cursor, out_selected_field);
          if (out_editing !== want.editing)
            flag_field("editing", want.editing, out_editing);
          if (out_blink_on !== want.blink_on)
            flag_field("blink_on", want.blink_on, out_blink_on);
          if (out_commit !== want.commit)
            flag_field("commit", want.commit, out_commit);
          if (want.commit) commit_cnt++;
        end
      end
      if (in_valid && in_ready)
        advance_editor(in_command, {in_load_year, in_load_month, in_load_day,
                                    in_load_hour, in_load_minute, in_load_second});
    end
    n_fail    <= fail_cnt;
    n_pending <= pending_views.size();
    n_checked <= checked_cnt;
    n_commits <= commit_cnt;
  end

endmodule

// ===== sim/calendar_time_field_editor_tb.sv =====
// ----------------------------------------------------------------------------
// calendar_time_field_editor_tb: testbench for the calendar time field editor
// directed edge cases, then random edit sessions under several blink periods,
// with bursty commands and a stalling result side; a checker compares results
// ----------------------------------------------------------------------------
module calendar_time_field_editor_tb;
  import cte_pkg::*;

  // command codes the block must ignore
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // every block input starts at a known value
  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              cfg_valid      = 1'b0;
  logic [HALF_W-1:0] cfg_data       = '0;
  logic              in_valid       = 1'b0;
  logic [2:0]        in_command     = '0;
  logic [6:0]        in_load_year   = '0;
  logic [3:0]        in_load_month  = '0;
  logic [4:0]        in_load_day    = '0;
  logic [4:0]        in_load_hour   = '0;
  logic [5:0]        in_load_minute = '0;
  logic [5:0]        in_load_second = '0;
  logic              out_ready      = 1'b0;

  logic              cfg_ready;
  logic              in_ready;
  logic              out_valid;
  logic [6:0]        out_year;
  logic [3:0]        out_month;
  logic [4:0]        out_day;
  logic [4:0]        out_hour;
  logic [5:0]        out_minute;
  logic [5:0]        out_second;
  logic [2:0]        out_selected_field;
  logic              out_editing;
  logic              out_blink_on;
  logic              out_commit;

  int n_fail;
  int n_pending;
  int n_checked;
  int n_commits;

  // stimulus bookkeeping
  int   sent_total  = 0;
  int   sent_work   = 0;   // commands that actually change something
  int   sessions    = 0;
  int   settings    = 0;
  int   burst_left  = 0;
  logic edit_shadow = 1'b0; // our own view of edit mode, to know what counts
  int   stall_mode  = 0;
  int   stall_left  = 0;

  calendar_time_field_editor dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_load_year       (in_load_year),
    .in_load_month      (in_load_month),
    .in_load_day        (in_load_day),
    .in_load_hour       (in_load_hour),
    .in_load_minute     (in_load_minute),
    .in_load_second     (in_load_second),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_year           (out_year),
    .out_month          (out_month),
    .out_day            (out_day),
    .out_hour           (out_hour),
    .out_minute         (out_minute),
    .out_second         (out_second),
    .out_selected_field (out_selected_field),
    .out_editing        (out_editing),
    .out_blink_on       (out_blink_on),
    .out_commit         (out_commit)
  );

  // checker sits beside the block and only watches
  cte_editor_checker result_watch (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_load_year       (in_load_year),
    .in_load_month      (in_load_month),
    .in_load_day        (in_load_day),
    .in_load_hour       (in_load_hour),
    .in_load_minute     (in_load_minute),
    .in_load_second     (in_load_second),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_year           (out_year),
    .out_month          (out_month),
    .out_day            (out_day),
    .out_hour           (out_hour),
    .out_minute         (out_minute),
    .out_second         (out_second),
    .out_selected_field (out_selected_field),
    .out_editing        (out_editing),
    .out_blink_on       (out_blink_on),
    .out_commit         (out_commit),
    .n_fail             (n_fail),
    .n_pending          (n_pending),
    .n_checked          (n_checked),
    .n_commits          (n_commits)
  );

  always #5 clk = ~clk;

  // result side stalls on a pattern of its own: after each run of random length
  // pick a new mode, from always ready down to mostly stalled
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 64);
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      2:       out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // random bits in every field, out-of-range values included
  function automatic cte_fields_t any_bits();
    cte_fields_t r;
    r.year   = 7'($urandom);
    r.month  = 4'($urandom);
    r.day    = 5'($urandom);
    r.hour   = 5'($urandom);
    r.minute = 6'($urandom);
    r.second = 6'($urandom);
    return r;
  endfunction

  // clock reading for a load: mostly legal, leaning on february and month
  // ends so the day repair gets exercised; one in four is raw bits
  function automatic cte_fields_t pick_reading();
    cte_fields_t r;
    r = any_bits();
    if ($urandom_range(0, 3) != 0) begin
      r.year   = 7'($urandom_range(0, 99));
      r.month  = ($urandom_range(0, 2) == 0) ? 4'd2 : 4'($urandom_range(1, 12));
      r.day    = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(28, 31))
                                             : 5'($urandom_range(1, 31));
      r.hour   = 5'($urandom_range(0, 23));
      r.minute = 6'($urandom_range(0, 59));
      r.second = 6'($urandom_range(0, 59));
    end
    return r;
  endfunction

  // one command transfer; the sender runs in bursts with random gaps between
  task automatic send_item(input logic [2:0] cmd, input cte_fields_t rd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      // valid only drops when there really is a gap, so it never falls and
      // rises within one time step
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_command <= cmd;
    {in_load_year, in_load_month, in_load_day,
     in_load_hour, in_load_minute, in_load_second} <= rd;
    do @(posedge clk); while (!in_ready);
    sent_total++;
    case (cmd)
      CMD_TICK, CMD_MODE:         sent_work++;
      CMD_NEXT, CMD_UP, CMD_DOWN: if (edit_shadow) sent_work++;
      CMD_LOAD:                   if (!edit_shadow) sent_work++;
      default: ;
    endcase
    if (cmd == CMD_MODE) edit_shadow = !edit_shadow;
  endtask

  // drop valid and wait until every outstanding result has come back,
  // then let the two-stage pipe run empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // the register is only written while the block is idle
  task automatic set_half_period(input logic [HALF_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // mostly full edit sessions (optional load, enter, random steps, leave),
  // some view-mode ticks and loads, and some raw noise including the spare
  // command codes and commands given in the wrong mode
  task automatic run_random(input int target);
    int         goal;
    int         n;
    int         r;
    logic [2:0] cmd;
    goal = sent_work + target;
    while (sent_work < goal) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        if (!edit_shadow) begin
          if ($urandom_range(0, 4) != 0) send_item(CMD_LOAD, pick_reading());
          send_item(CMD_MODE, any_bits());
          sessions++;
        end
        n = $urandom_range(1, 24);
        repeat (n) begin
          r = $urandom_range(0, 19);
          if (r < 6) cmd = CMD_NEXT;
          else if (r < 12) cmd = CMD_UP;
          else if (r < 17) cmd = CMD_DOWN;
          else cmd = CMD_TICK;
          send_item(cmd, any_bits());
        end
        // now and then the session stays open and the next one continues it
        if ($urandom_range(0, 9) != 0) send_item(CMD_MODE, any_bits());
      end else if (r < 8) begin
        // ticks in view mode keep the blink flag running while it is hidden
        n = $urandom_range(1, 8);
        repeat (n) send_item(($urandom_range(0, 9) < 7) ? CMD_TICK : CMD_LOAD,
                             pick_reading());
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(3'($urandom_range(0, 7)), any_bits());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset half period
    // load with every field at its all-ones value, far out of range
    send_item(CMD_LOAD, {7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63});
    // edit commands in view mode and the spare codes are ignored
    send_item(CMD_NEXT, any_bits());
    send_item(CMD_UP, any_bits());
    send_item(CMD_SPARE_6, any_bits());
    send_item(CMD_SPARE_7, any_bits());
    // enter edit mode, a load is now ignored
    send_item(CMD_MODE, any_bits());
    send_item(CMD_LOAD, '0);
    // year: up from above max wraps to min, down from min wraps to max
    send_item(CMD_UP, any_bits());
    send_item(CMD_DOWN, any_bits());
    // month: same wrap from an invalid month code
    send_item(CMD_NEXT, any_bits());
    send_item(CMD_UP, any_bits());
    send_item(CMD_DOWN, any_bits());
    // day: up past 31 overflows and is repaired to 1, down from 1 gives 31
    send_item(CMD_NEXT, any_bits());
    send_item(CMD_UP, any_bits());
    send_item(CMD_DOWN, any_bits());
    // hour: wrap both ways
    send_item(CMD_NEXT, any_bits());
    send_item(CMD_UP, any_bits());
    send_item(CMD_DOWN, any_bits());
    // minute up from 63, second down from 63
    send_item(CMD_NEXT, any_bits());
    send_item(CMD_UP, any_bits());
    send_item(CMD_NEXT, any_bits());
    send_item(CMD_DOWN, any_bits());
    // cursor wraps from second back to year
    send_item(CMD_NEXT, any_bits());
    send_item(CMD_TICK, any_bits());
    // leave edit mode, commit pulses
    send_item(CMD_MODE, any_bits());

    // random part under several half periods, the extremes among them
    set_half_period(16'd1);
    run_random(250);
    set_half_period(16'hffff);
    run_random(150);
    // lowered below the running tick count, and zero: must behave like one
    set_half_period(16'd0);
    run_random(200);
    set_half_period(16'd3);
    run_random(200);
    set_half_period(16'd2);
    run_random(200);

    settle();
    $display("sent %0d commands (%0d effective), %0d edit sessions, %0d half-period writes",
             sent_total, sent_work, sessions, settings);
    $display("compared %0d results, %0d with commit, %0d field errors",
             n_checked, n_commits, n_fail);
    if (n_fail == 0 && n_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== calendar_time_field_editor.f =====
sv/cte_pkg.sv
sv/cte_step.sv
sv/calendar_time_field_editor.sv
sim/cte_editor_checker.sv
sim/calendar_time_field_editor_tb.sv
